>>> sv/rng_pkg.sv
package rng_pkg;

  localparam int MAX_NODES  = 64;
  localparam int COORD_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int PT_W    = 2 * COORD_BITS;
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int SUM_W   = SQ_W + 1;
  localparam int RAD_W   = 16;
  localparam int LIM_W   = 2 * RAD_W;
  localparam int CMP_W   = (SUM_W > LIM_W) ? SUM_W : LIM_W;
  localparam int IN_W    = 16;
  localparam int NODE_W  = 6;
  localparam int MASK_W  = 64;
  localparam int TOTAL_W = 6;
  localparam int NCFG_W  = 7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_RADIUS     = 1'b0;
  localparam logic REG_NODE_COUNT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] tag;
  } dist_req_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] tag;
    logic             hit;
    logic             busy;
  } dist_res_t;

  // Sign-extend the 16-bit input, then wrap it to the stored coordinate width.
  function automatic coord_t to_coord(input logic signed [IN_W-1:0] v);
    logic signed [31:0] ext;
    ext = 32'(v);
    return ext[COORD_BITS-1:0];
  endfunction

endpackage

>>> sv/rng_point_mem.sv
module rng_point_mem import rng_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [PT_W-1:0]  wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [PT_W-1:0]  rd_data
);

  logic [PT_W-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/rng_dist_unit.sv
module rng_dist_unit import rng_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  dist_req_t        req,
  input  logic [PT_W-1:0]  point,
  input  coord_t           qx,
  input  coord_t           qy,
  input  logic [LIM_W-1:0] limit,
  output dist_res_t        res
);

  // Three stages: absolute differences, squares, then sum and compare.
  logic                  s1_valid, s2_valid, s3_valid;
  logic [IDX_W-1:0]      s1_tag, s2_tag, s3_tag;
  logic [COORD_BITS-1:0] adx, ady;
  logic [SQ_W-1:0]       sqx, sqy;
  logic                  s3_hit;

  logic [COORD_BITS-1:0] adx_next, ady_next;
  logic                  hit_next;

  always_comb begin
    logic signed [COORD_BITS:0] dx, dy;
    logic signed [COORD_BITS:0] mx, my;
    logic [SUM_W-1:0]           sum;
    coord_t                     px, py;
    px = point[PT_W-1:COORD_BITS];
    py = point[COORD_BITS-1:0];
    dx = (COORD_BITS+1)'(px) - (COORD_BITS+1)'(qx);
    dy = (COORD_BITS+1)'(py) - (COORD_BITS+1)'(qy);
    mx = dx[COORD_BITS] ? -dx : dx;
    my = dy[COORD_BITS] ? -dy : dy;
    adx_next = mx[COORD_BITS-1:0];
    ady_next = my[COORD_BITS-1:0];
    sum = SUM_W'(sqx) + SUM_W'(sqy);
    hit_next = CMP_W'(sum) <= CMP_W'(limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag <= req.tag;
    adx    <= adx_next;
    ady    <= ady_next;
    s2_tag <= s1_tag;
    sqx    <= SQ_W'(adx) * SQ_W'(adx);
    sqy    <= SQ_W'(ady) * SQ_W'(ady);
    s3_tag <= s2_tag;
    s3_hit <= hit_next;
  end

  assign res.valid = s3_valid;
  assign res.tag   = s3_tag;
  assign res.hit   = s3_hit;
  assign res.busy  = s1_valid | s2_valid | s3_valid;

endmodule

>>> sv/radius_neighbor_graph_top.sv
// Fixed-radius neighbor search over a table of up to 64 points. A load word writes one point
// and gives no result. A query word reads the named point, then streams every stored point
// below node_count through one pipelined squared-distance unit, one point per cycle on the
// table's single read port, and returns the neighbor mask and its count. After a query is
// taken, input stall stays high while the block fetches the queried point, examines every
// node below node_count (capped at 64), drains the distance pipeline and hands over the
// result. A node_count of zero skips the sweep. The finished result sits in an output
// register, so the next word is taken while it waits; a second query that finishes before
// the first result is taken holds, with stall still high, until it is.
module radius_neighbor_graph_top import rng_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [RAD_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [NODE_W-1:0]            node_index,
  input  logic signed [IN_W-1:0]       x_coord,
  input  logic signed [IN_W-1:0]       y_coord,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [NODE_W-1:0]            queried_node,
  output logic [MASK_W-1:0]            neighbor_mask,
  output logic [TOTAL_W-1:0]           neighbor_total
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_QLOAD = 5'b00010,
    S_SWEEP = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t             state;
  logic [RAD_W-1:0]   radius;
  logic [NCFG_W-1:0]  node_count;
  logic [CNT_W-1:0]   j;
  logic [CNT_W-1:0]   count;
  logic [NODE_W-1:0]  qidx;
  coord_t             qx, qy;
  logic [LIM_W-1:0]   limit;
  logic [MASK_W-1:0]  mask;
  logic [TOTAL_W-1:0] total;
  dist_req_t          req;

  logic               in_acc;
  logic               out_acc;
  logic               idx_ok;
  logic [CNT_W-1:0]   count_sat;
  logic [IDX_W-1:0]   rd_addr;
  logic [PT_W-1:0]    rd_data;
  logic               wr_en;
  dist_res_t          res;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign idx_ok   = 32'(node_index) < MAX_NODES;
  assign count_sat = (32'(node_count) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count);
  assign wr_en    = in_acc && (op == OP_LOAD) && idx_ok;
  assign rd_addr  = (state == S_IDLE) ? IDX_W'(node_index) : j[IDX_W-1:0];

  rng_point_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(node_index)),
    .wr_data ({to_coord(x_coord), to_coord(y_coord)}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rng_dist_unit u_dist (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .point (rd_data),
    .qx    (qx),
    .qy    (qy),
    .limit (limit),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= '0;
      node_count <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RADIUS:     radius     <= cfg_data;
        REG_NODE_COUNT: node_count <= cfg_data[NCFG_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req.valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      req.valid <= (state == S_SWEEP);
      req.tag   <= j[IDX_W-1:0];
      if (out_acc && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (op == OP_QUERY)) begin
            state <= S_QLOAD;
          end
        end
        S_QLOAD: begin
          state <= (count == '0) ? S_DRAIN : S_SWEEP;
        end
        S_SWEEP: begin
          if (j + 1'b1 == count) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!req.valid && !res.busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_stall == 1'b0) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        qidx  <= node_index;
        count <= idx_ok ? count_sat : '0;
        limit <= LIM_W'(radius) * LIM_W'(radius);
        j     <= '0;
        mask  <= '0;
        total <= '0;
      end
      S_QLOAD: begin
        qx <= rd_data[PT_W-1:COORD_BITS];
        qy <= rd_data[COORD_BITS-1:0];
      end
      S_SWEEP: begin
        j <= j + 1'b1;
      end
      S_DRAIN, S_DONE: begin
      end
      default: begin
      end
    endcase
    // A node is never its own neighbor.
    if (res.valid && res.hit && (NODE_W'(res.tag) != qidx)) begin
      mask[res.tag] <= 1'b1;
      total         <= total + 1'b1;
    end
    if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      queried_node   <= qidx;
      neighbor_mask  <= MASK_W'(mask);
      neighbor_total <= total;
    end
  end

endmodule

>>> verif/tb_radius_neighbor_graph_top.sv
module tb_radius_neighbor_graph_top;
  import rng_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 100;

  typedef struct {
    logic [NODE_W-1:0]  node;
    logic [MASK_W-1:0]  mask;
    logic [TOTAL_W-1:0] total;
  } nbr_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic                   cfg_index;
  logic [RAD_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic                   op;
  logic [NODE_W-1:0]      node_index;
  logic signed [IN_W-1:0] x_coord;
  logic signed [IN_W-1:0] y_coord;
  logic                   out_valid;
  logic                   out_stall;
  logic [NODE_W-1:0]      queried_node;
  logic [MASK_W-1:0]      neighbor_mask;
  logic [TOTAL_W-1:0]     neighbor_total;

  // Shadow copy of the point table and registers.
  coord_t             pt_x [MAX_NODES];
  coord_t             pt_y [MAX_NODES];
  logic [RAD_W-1:0]   radius_q;
  logic [NCFG_W-1:0]  ncount_q;

  nbr_result_t pending_results[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  bit          idle_on = 1'b1;
  bit          stall_on = 1'b1;

  radius_neighbor_graph_top dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .node_index(node_index), .x_coord(x_coord), .y_coord(y_coord),
    .out_valid(out_valid), .out_stall(out_stall),
    .queried_node(queried_node), .neighbor_mask(neighbor_mask),
    .neighbor_total(neighbor_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic nbr_result_t predict_neighbors(logic [NODE_W-1:0] idx);
    nbr_result_t r;
    int          count;
    longint      dx;
    longint      dy;
    longint      limit;
    r.node  = idx;
    r.mask  = '0;
    r.total = '0;
    count = (ncount_q > MAX_NODES) ? MAX_NODES : int'(ncount_q);
    limit = longint'(radius_q) * longint'(radius_q);
    for (int j = 0; j < count; j++) begin
      if (j != int'(idx)) begin
        dx = longint'(pt_x[j]) - longint'(pt_x[idx]);
        dy = longint'(pt_y[j]) - longint'(pt_y[idx]);
        if (dx * dx + dy * dy <= limit) begin
          r.mask[j] = 1'b1;
          r.total   = r.total + 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  // Sends one word; called and returning at a falling edge.
  task automatic send_word(logic o, logic [NODE_W-1:0] idx,
                           logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid   = 1'b0;
      op         = 1'($urandom);
      node_index = NODE_W'($urandom);
      x_coord    = IN_W'($urandom);
      y_coord    = IN_W'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid   = 1'b1;
    op         = o;
    node_index = idx;
    x_coord    = x;
    y_coord    = y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (o == OP_LOAD) begin
      pt_x[idx] = coord_t'(x);
      pt_y[idx] = coord_t'(y);
    end else begin
      pending_results.push_back(predict_neighbors(idx));
    end
    @(negedge clk);
  endtask

  task automatic load_point(logic [NODE_W-1:0] idx, int x, int y);
    send_word(OP_LOAD, idx, IN_W'(x), IN_W'(y));
  endtask

  task automatic query_node(logic [NODE_W-1:0] idx);
    send_word(OP_QUERY, idx, IN_W'($urandom), IN_W'($urandom));
  endtask

  // Waits until every result is back, then lets a trailing load drain.
  task automatic settle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = RAD_W'(data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_RADIUS) radius_q = RAD_W'(data);
    else ncount_q = NCFG_W'(data);
  endtask

  task automatic configure(int unsigned rad, int unsigned cnt);
    settle();
    write_reg(REG_RADIUS, rad);
    write_reg(REG_NODE_COUNT, cnt);
  endtask

  // Every entry gets written first so no query ever reads an unwritten point.
  task automatic test_fill_table();
    for (int i = 0; i < MAX_NODES; i++)
      load_point(NODE_W'(i), $urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100);
  endtask

  task automatic test_reset_registers();
    query_node(0);
    query_node(63);
  endtask

  task automatic test_coord_extremes();
    configure(16'hFFFF, 4);
    load_point(0, -32768, -32768);
    load_point(1, 32767, 32767);
    load_point(2, -32768, 32767);
    load_point(3, 32767, -32768);
    for (int i = 0; i < 4; i++) query_node(NODE_W'(i));
    // One unit short of the edge-to-edge distance.
    configure(16'hFFFE, 4);
    query_node(0);
    query_node(2);
  endtask

  task automatic test_zero_radius();
    configure(0, 8);
    load_point(4, 7, -7);
    load_point(5, 7, -7);
    load_point(6, 7, -6);
    query_node(4);
    query_node(6);
  endtask

  task automatic test_count_limits();
    configure(300, 64);
    query_node(63);
    configure(300, 127);
    query_node(10);
    configure(300, 65);
    query_node(0);
    // A node above the count is still answered against the nodes below it.
    configure(300, 5);
    query_node(40);
    configure(300, 1);
    query_node(0);
  endtask

  task automatic test_random_traffic();
    bit          wide;
    int          span;
    int          bx;
    int          by;
    int unsigned rad;
    int unsigned cnt;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph >= 8) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      wide = ($urandom_range(0, 2) == 0);
      span = $urandom_range(4, 200);
      bx   = $urandom_range(0, 65535) - 32768;
      by   = $urandom_range(0, 65535) - 32768;
      if (wide) rad = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(30000, 65535);
      else rad = $urandom_range(0, 2 * span);
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(0, 64);
      configure(rad, cnt);
      repeat (100) begin
        if ($urandom_range(0, 9) < 7) begin
          if (wide)
            load_point(NODE_W'($urandom_range(0, 63)), $urandom_range(0, 65535) - 32768,
                       $urandom_range(0, 65535) - 32768);
          else
            load_point(NODE_W'($urandom_range(0, 63)), bx + $urandom_range(0, 2 * span) - span,
                       by + $urandom_range(0, 2 * span) - span);
        end else begin
          query_node(NODE_W'($urandom_range(0, 63)));
        end
      end
    end
  endtask

  // Result stall: random bursts, none in the last phases.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    nbr_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, node", 64'(queried_node), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (queried_node !== want.node)
          report_mismatch("queried_node", 64'(queried_node), 64'(want.node));
        if (neighbor_mask !== want.mask)
          report_mismatch("neighbor_mask", neighbor_mask, want.mask);
        if (neighbor_total !== want.total)
          report_mismatch("neighbor_total", 64'(neighbor_total), 64'(want.total));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_RADIUS;
    cfg_data   = '0;
    in_valid   = 1'b0;
    op         = OP_LOAD;
    node_index = '0;
    x_coord    = '0;
    y_coord    = '0;
    radius_q   = '0;
    ncount_q   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fill_table();
    test_reset_registers();
    test_coord_extremes();
    test_zero_radius();
    test_count_limits();
    test_random_traffic();
    settle();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> radius_neighbor_graph_top.f
sv/rng_pkg.sv
sv/rng_point_mem.sv
sv/rng_dist_unit.sv
sv/radius_neighbor_graph_top.sv
verif/tb_radius_neighbor_graph_top.sv
